// ===== sv/pif_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pif_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH    = 256;
    localparam int CNT_W          = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRY_COUNT_W  = 9;
    localparam int ADDR_W         = 32;
    localparam int PROTO_W        = 8;

    // IPv4 protocol numbers that the protocol check knows.
    localparam logic [PROTO_W-1:0] PROTO_ICMP = 8'd1;
    localparam logic [PROTO_W-1:0] PROTO_TCP  = 8'd6;
    localparam logic [PROTO_W-1:0] PROTO_UDP  = 8'd17;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TCP_ALLOWED  = 2'd0;
    localparam logic [1:0] CFG_ICMP_ALLOWED = 2'd1;
    localparam logic [1:0] CFG_UDP_ALLOWED  = 2'd2;

    typedef enum logic [1:0] {
        MODE_CHECK  = 2'd0,
        MODE_ADD    = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_CLEAR  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WAIT
    } state_t;

    // Search token that walks down the cell chain one cell per cycle.
    typedef struct packed {
        logic wave;
        logic found;
    } token_t;

    // Controls broadcast to every cell.
    typedef struct packed {
        logic [ADDR_W-1:0] key;
        logic              do_remove;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ===== sv/pif_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pif_cell (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire pif_pkg::cell_ctl_t        ctl,
    input  wire logic                      live,
    input  wire logic                      wr_en,
    input  wire logic [pif_pkg::ADDR_W-1:0] next_addr,
    input  wire pif_pkg::token_t           tok_in,
    output logic [pif_pkg::ADDR_W-1:0]     addr,
    output pif_pkg::token_t                tok_out
);

    logic [pif_pkg::ADDR_W-1:0] addr_reg;
    logic                       wave_reg;
    logic                       found_reg;
    logic                       match;
    logic                       hit;

    // Compare the stored entry against the key while the token sits here.
    assign match = tok_in.wave & live & (addr_reg == ctl.key);
    assign hit   = tok_in.found | match;

    // Hand the token to the next cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            wave_reg  <= tok_in.wave;
            found_reg <= tok_in.wave & hit;
        end
    end

    // Entry storage: an append writes it, a remove at or before this cell
    // pulls the entry of the next cell in to close the gap.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            addr_reg <= ctl.key;
        end
        else if (tok_in.wave && ctl.do_remove && hit)
        begin
            addr_reg <= next_addr;
        end
    end

    assign addr          = addr_reg;
    assign tok_out.wave  = wave_reg;
    assign tok_out.found = found_reg;

endmodule

`default_nettype wire

// ===== sv/protocol_and_source_ip_packet_filter.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Packet filter with a source-address blocklist held in a chain of
// TABLE_DEPTH cells, one address per cell. A search token enters the first
// cell and moves one cell per clock, so a packet check or a remove waits for
// the token to pass the whole cell chain; an add or a clear skips the scan. A
// remove closes the gap as the token passes, the matching cell and each cell
// after it taking the address of its next neighbor. The result sits in an
// output register, so the block takes the next input beat while a result still
// waits downstream. The configuration port is always ready; the user must write
// it only while idle, as the block itself does not enforce this.
module protocol_and_source_ip_packet_filter (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [1:0]                         mode,
    input  wire logic [pif_pkg::PROTO_W-1:0]        ip_protocol,
    input  wire logic [pif_pkg::ADDR_W-1:0]         address,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic                                    drop,
    output logic [1:0]                              status,
    output logic [pif_pkg::ENTRY_COUNT_W-1:0]       entry_count,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [1:0]                         cfg_index,
    input  wire logic                               cfg_data
);

    localparam int DEPTH = pif_pkg::TABLE_DEPTH;
    localparam int CW    = pif_pkg::CNT_W;

    pif_pkg::state_t                  state_reg;
    pif_pkg::state_t                  state_next;
    pif_pkg::mode_t                   mode_reg;
    logic [pif_pkg::PROTO_W-1:0]      proto_reg;
    logic [pif_pkg::ADDR_W-1:0]       key_reg;
    logic [CW-1:0]                    count_reg;
    logic [CW-1:0]                    count_next;
    logic                             start_reg;
    logic                             found_reg;
    logic                             tcp_allowed_reg;
    logic                             icmp_allowed_reg;
    logic                             udp_allowed_reg;
    logic                             out_valid_reg;
    logic                             drop_reg;
    logic                             drop_next;
    logic [1:0]                       status_reg;
    pif_pkg::status_t                 status_next;
    logic [pif_pkg::ENTRY_COUNT_W-1:0] entry_count_reg;

    logic                             accept;
    logic                             commit;
    logic                             scan_done;
    logic                             proto_blocked;
    logic                             table_full;
    logic                             add_write;

    pif_pkg::cell_ctl_t               ctl;
    pif_pkg::token_t                  tok [DEPTH+1];
    logic [pif_pkg::ADDR_W-1:0]       cell_addr [DEPTH];

    assign cfg_ready = 1'b1;
    assign accept    = in_valid & in_ready;
    assign scan_done = tok[DEPTH].wave;
    assign table_full = (count_reg == CW'(DEPTH));
    assign add_write  = commit & (mode_reg == pif_pkg::MODE_ADD) & ~table_full;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pif_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and handshake controls.
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        commit     = 1'b0;
        case (state_reg)
            pif_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if ((pif_pkg::mode_t'(mode) == pif_pkg::MODE_CHECK) ||
                        (pif_pkg::mode_t'(mode) == pif_pkg::MODE_REMOVE))
                    begin
                        state_next = pif_pkg::S_SCAN;
                    end
                    else
                    begin
                        state_next = pif_pkg::S_WAIT;
                    end
                end
            end
            pif_pkg::S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = pif_pkg::S_WAIT;
                end
            end
            pif_pkg::S_WAIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    commit     = 1'b1;
                    state_next = pif_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pif_pkg::S_IDLE;
            end
        endcase
    end

    // Protocol check against the allow flags.
    always_comb
    begin
        case (proto_reg)
            pif_pkg::PROTO_UDP:  proto_blocked = ~udp_allowed_reg;
            pif_pkg::PROTO_TCP:  proto_blocked = ~tcp_allowed_reg;
            pif_pkg::PROTO_ICMP: proto_blocked = ~icmp_allowed_reg;
            default:             proto_blocked = 1'b0;
        endcase
    end

    // Result and new entry count of the finished item.
    always_comb
    begin
        drop_next   = 1'b0;
        status_next = pif_pkg::ST_OK;
        count_next  = count_reg;
        case (mode_reg)
            pif_pkg::MODE_CHECK:
            begin
                drop_next = proto_blocked | found_reg;
            end
            pif_pkg::MODE_ADD:
            begin
                if (table_full)
                begin
                    status_next = pif_pkg::ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            pif_pkg::MODE_REMOVE:
            begin
                if (found_reg)
                begin
                    count_next = count_reg - CW'(1);
                end
                else
                begin
                    status_next = pif_pkg::ST_NOT_FOUND;
                end
            end
            pif_pkg::MODE_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // Control registers: start pulse, search outcome, count, output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg     <= 1'b0;
            found_reg     <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            start_reg <= accept &&
                ((pif_pkg::mode_t'(mode) == pif_pkg::MODE_CHECK) ||
                 (pif_pkg::mode_t'(mode) == pif_pkg::MODE_REMOVE));
            if (accept)
            begin
                found_reg <= 1'b0;
            end
            else if (scan_done)
            begin
                found_reg <= tok[DEPTH].found;
            end
            if (commit)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tcp_allowed_reg  <= 1'b1;
            icmp_allowed_reg <= 1'b0;
            udp_allowed_reg  <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                pif_pkg::CFG_TCP_ALLOWED:  tcp_allowed_reg  <= cfg_data;
                pif_pkg::CFG_ICMP_ALLOWED: icmp_allowed_reg <= cfg_data;
                pif_pkg::CFG_UDP_ALLOWED:  udp_allowed_reg  <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // Latched input beat and output payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg  <= pif_pkg::mode_t'(mode);
            proto_reg <= ip_protocol;
            key_reg   <= address;
        end
        if (commit)
        begin
            drop_reg        <= drop_next;
            status_reg      <= status_next;
            entry_count_reg <= pif_pkg::ENTRY_COUNT_W'(count_next);
        end
    end

    // Broadcast controls and the head of the token chain.
    assign ctl.key       = key_reg;
    assign ctl.do_remove = (mode_reg == pif_pkg::MODE_REMOVE);
    assign tok[0].wave   = start_reg;
    assign tok[0].found  = 1'b0;

    // The cell chain.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                       live;
        logic                       wr_en;
        logic [pif_pkg::ADDR_W-1:0] next_addr;

        assign live  = (CW'(i) < count_reg);
        assign wr_en = add_write & (count_reg == CW'(i));

        if (i < DEPTH - 1)
        begin : g_mid
            assign next_addr = cell_addr[i+1];
        end
        else
        begin : g_last
            assign next_addr = cell_addr[i];
        end

        pif_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .live      (live),
            .wr_en     (wr_en),
            .next_addr (next_addr),
            .tok_in    (tok[i]),
            .addr      (cell_addr[i]),
            .tok_out   (tok[i+1])
        );
    end

    assign out_valid   = out_valid_reg;
    assign drop        = drop_reg;
    assign status      = status_reg;
    assign entry_count = entry_count_reg;

endmodule

`default_nettype wire

// ===== sv/pif_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pif_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    input  wire logic                               in_ready,
    input  wire logic                               out_valid,
    input  wire logic                               out_ready,
    input  wire logic                               drop,
    input  wire logic [1:0]                         status,
    input  wire logic [pif_pkg::ENTRY_COUNT_W-1:0]  entry_count
);

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(drop) &&
            $stable(status) && $stable(entry_count))
        else $error("stalled result beat changed");

    // Only one item is in work at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in work");

    // A dropped packet never carries a command status.
    a_drop_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && drop |-> status == pif_pkg::ST_OK)
        else $error("drop with nonzero status");

    // The count never passes the table depth.
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> int'(entry_count) <= pif_pkg::TABLE_DEPTH)
        else $error("entry count above table depth");

    // No status code beyond not-found is produced.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= pif_pkg::ST_NOT_FOUND)
        else $error("undefined status code");

endmodule

bind protocol_and_source_ip_packet_filter pif_checker u_pif_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .drop        (drop),
    .status      (status),
    .entry_count (entry_count)
);

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import pif_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int LONG_HOLD   = 400;

    typedef struct packed {
        logic                     drop;
        status_t                  status;
        logic [ENTRY_COUNT_W-1:0] entry_count;
    } verdict_t;

    typedef struct {
        mode_t        mode;
        logic [7:0]   proto;
        logic [31:0]  addr;
        bit           typed;
        verdict_t     want;
    } filter_req_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [1:0]               mode = MODE_CHECK;
    logic [PROTO_W-1:0]       ip_protocol = '0;
    logic [ADDR_W-1:0]        address = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic                     drop;
    logic [1:0]               status;
    logic [ENTRY_COUNT_W-1:0] entry_count;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [1:0]               cfg_index = CFG_TCP_ALLOWED;
    logic                     cfg_data = 1'b0;

    // Shadow copy of the blocklist and the protocol allow registers.
    logic [31:0] blocklist_shadow[$];
    logic        tcp_ok = 1'b1;
    logic        icmp_ok = 1'b0;
    logic        udp_ok = 1'b0;

    verdict_t    pending_verdicts[$];
    filter_req_t directed_rows[$];
    logic [31:0] addr_pool [8];
    int          error_count = 0;
    int          result_count = 0;
    int          cycle_count = 0;
    bit          tx_burst = 1'b0;
    bit          rx_burst = 1'b0;
    bit          long_hold_req = 1'b0;

    protocol_and_source_ip_packet_filter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .ip_protocol (ip_protocol),
        .address     (address),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .drop        (drop),
        .status      (status),
        .entry_count (entry_count),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // Clock generation.
    initial
    begin
        forever #10 clk = ~clk;
    end

    // Run watchdog.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Computes the verdict of one beat and updates the shadow state.
    function automatic verdict_t filter_predict(mode_t m, logic [7:0] proto,
                                                logic [31:0] addr);
        verdict_t v;
        int hit;
        v.drop = 1'b0;
        v.status = ST_OK;
        hit = -1;
        foreach (blocklist_shadow[i])
        begin
            if (hit < 0 && blocklist_shadow[i] == addr)
                hit = i;
        end
        case (m)
            MODE_CHECK:
                v.drop = (proto == PROTO_TCP && !tcp_ok) ||
                         (proto == PROTO_UDP && !udp_ok) ||
                         (proto == PROTO_ICMP && !icmp_ok) || hit >= 0;
            MODE_ADD:
                if (blocklist_shadow.size() >= TABLE_DEPTH)
                    v.status = ST_FULL;
                else
                    blocklist_shadow.push_back(addr);
            MODE_REMOVE:
                if (hit >= 0)
                    blocklist_shadow.delete(hit);
                else
                    v.status = ST_NOT_FOUND;
            default:
                blocklist_shadow.delete();
        endcase
        v.entry_count = ENTRY_COUNT_W'(blocklist_shadow.size());
        return v;
    endfunction

    function automatic filter_req_t row(mode_t m, logic [7:0] proto, logic [31:0] addr,
                                        bit typed, logic d, status_t st, int cnt);
        filter_req_t r;
        r.mode = m;
        r.proto = proto;
        r.addr = addr;
        r.typed = typed;
        r.want.drop = d;
        r.want.status = st;
        r.want.entry_count = ENTRY_COUNT_W'(cnt);
        return r;
    endfunction

    // Half the protocols are the three that the check knows.
    function automatic logic [7:0] pick_proto();
        case ($urandom_range(0, 5))
            0: return PROTO_TCP;
            1: return PROTO_UDP;
            2: return PROTO_ICMP;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly addresses from a small pool, so that lookups and removes hit.
    function automatic logic [31:0] pick_addr();
        if ($urandom_range(0, 9) < 6)
            return addr_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("MISMATCH result %0d %s: got %0d expected %0d",
                 result_count, field, got, want);
        error_count++;
    endtask

    // Offers one input beat and records its expected verdict on accept.
    task automatic send_request(mode_t m, logic [7:0] proto, logic [31:0] addr,
                                bit typed = 1'b0, verdict_t want = '0);
        int gap;
        verdict_t predicted;
        if ($urandom_range(0, 31) == 0)
            tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 7);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        ip_protocol <= proto;
        address <= addr;
        do @(posedge clk); while (!(in_valid && in_ready));
        predicted = filter_predict(m, proto, addr);
        pending_verdicts.push_back(typed ? want : predicted);
    endtask

    // Stops offering beats and waits for every outstanding result.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        case (idx)
            CFG_TCP_ALLOWED:  tcp_ok = val;
            CFG_ICMP_ALLOWED: icmp_ok = val;
            default:          udp_ok = val;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_mix(int n);
        int pick;
        mode_t m;
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(0, 99);
            m = pick < 45 ? MODE_CHECK : pick < 70 ? MODE_ADD :
                pick < 95 ? MODE_REMOVE : MODE_CLEAR;
            send_request(m, pick_proto(), pick_addr());
        end
    endtask

    // Result sink: random stalls, one long hold on request, and checking.
    initial
    begin : result_sink
        int gap;
        verdict_t want;
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                gap = LONG_HOLD;
            end
            else
            begin
                if ($urandom_range(0, 31) == 0)
                    rx_burst = !rx_burst;
                gap = rx_burst ? 0 : $urandom_range(0, 7);
            end
            if (gap > 0)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
            result_count++;
            if (pending_verdicts.size() == 0)
            begin
                report_mismatch("unexpected beat", 1, 0);
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (drop !== want.drop)
                    report_mismatch("drop", drop, want.drop);
                if (status !== want.status)
                    report_mismatch("status", status, want.status);
                if (entry_count !== want.entry_count)
                    report_mismatch("entry_count", entry_count, want.entry_count);
            end
        end
    end

    // Stimulus.
    initial
    begin
        addr_pool[0] = 32'h0000_0000;
        addr_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 8; i++)
            addr_pool[i] = $urandom;

        // Directed table, run with the reset configuration.
        directed_rows.push_back(row(MODE_CHECK,  PROTO_TCP,  32'h0000_0000, 1, 0, ST_OK, 0));
        directed_rows.push_back(row(MODE_CHECK,  PROTO_UDP,  32'hFFFF_FFFF, 1, 1, ST_OK, 0));
        directed_rows.push_back(row(MODE_CHECK,  PROTO_ICMP, 32'h1234_5678, 1, 1, ST_OK, 0));
        directed_rows.push_back(row(MODE_CHECK,  8'hFF,      32'hFFFF_FFFF, 1, 0, ST_OK, 0));
        directed_rows.push_back(row(MODE_CHECK,  8'h00,      32'h0000_0000, 1, 0, ST_OK, 0));
        directed_rows.push_back(row(MODE_REMOVE, 8'h00, 32'h1234_5678, 1, 0, ST_NOT_FOUND, 0));
        directed_rows.push_back(row(MODE_ADD,    8'h00,      32'hFFFF_FFFF, 1, 0, ST_OK, 1));
        directed_rows.push_back(row(MODE_ADD,    8'h00,      32'h0000_0000, 0, 0, ST_OK, 0));
        directed_rows.push_back(row(MODE_ADD,    8'h00,      32'hC0A8_0001, 0, 0, ST_OK, 0));
        // A duplicate add stores the address a second time.
        directed_rows.push_back(row(MODE_ADD,    8'h00,      32'hC0A8_0001, 0, 0, ST_OK, 0));
        directed_rows.push_back(row(MODE_CHECK,  PROTO_TCP,  32'hC0A8_0001, 0, 0, ST_OK, 0));
        directed_rows.push_back(row(MODE_CHECK,  PROTO_TCP,  32'hFFFF_FFFF, 0, 0, ST_OK, 0));
        directed_rows.push_back(row(MODE_CHECK,  8'd200,     32'h0000_0000, 0, 0, ST_OK, 0));
        directed_rows.push_back(row(MODE_CHECK,  PROTO_TCP,  32'hC0A8_0002, 0, 0, ST_OK, 0));
        // Remove takes only the first of two matches.
        directed_rows.push_back(row(MODE_REMOVE, 8'h00,      32'hC0A8_0001, 0, 0, ST_OK, 0));
        directed_rows.push_back(row(MODE_CHECK,  PROTO_TCP,  32'hC0A8_0001, 0, 0, ST_OK, 0));
        // Commands ignore the protocol field.
        directed_rows.push_back(row(MODE_ADD,    8'hFF,      32'h0A00_0001, 0, 0, ST_OK, 0));
        directed_rows.push_back(row(MODE_REMOVE, 8'hFF,      32'hFFFF_FFFF, 0, 0, ST_OK, 0));
        directed_rows.push_back(row(MODE_REMOVE, 8'h00,      32'h0A00_0001, 0, 0, ST_OK, 0));
        directed_rows.push_back(row(MODE_REMOVE, 8'h00,      32'hC0A8_0001, 0, 0, ST_OK, 0));
        directed_rows.push_back(row(MODE_REMOVE, 8'h00, 32'hC0A8_0001, 1, 0, ST_NOT_FOUND, 1));
        directed_rows.push_back(row(MODE_CLEAR,  8'hAA,      32'h5555_5555, 1, 0, ST_OK, 0));
        directed_rows.push_back(row(MODE_CHECK,  8'h00,      32'h0000_0000, 1, 0, ST_OK, 0));
        directed_rows.push_back(row(MODE_CLEAR,  8'h00,      32'h0000_0000, 1, 0, ST_OK, 0));

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].mode, directed_rows[i].proto,
                         directed_rows[i].addr, directed_rows[i].typed,
                         directed_rows[i].want);
        drain();

        // Every protocol refused.
        write_reg(CFG_TCP_ALLOWED, 1'b0);
        write_reg(CFG_ICMP_ALLOWED, 1'b0);
        write_reg(CFG_UDP_ALLOWED, 1'b0);
        send_random_mix(100);
        drain();

        // Every protocol allowed; fill the table to capacity under a long stall.
        write_reg(CFG_TCP_ALLOWED, 1'b1);
        write_reg(CFG_ICMP_ALLOWED, 1'b1);
        write_reg(CFG_UDP_ALLOWED, 1'b1);
        long_hold_req = 1'b1;
        while (blocklist_shadow.size() < TABLE_DEPTH - 1)
            send_request(MODE_ADD, pick_proto(),
                         (blocklist_shadow.size() % 40 == 3) ?
                         addr_pool[blocklist_shadow.size() % 8] : $urandom);
        // The last slot holds a pool address, so the end of the table is searched.
        send_request(MODE_ADD, pick_proto(), addr_pool[7]);
        repeat (3) send_request(MODE_ADD, pick_proto(), $urandom);
        send_request(MODE_CHECK, pick_proto(), addr_pool[7]);
        send_request(MODE_REMOVE, pick_proto(), addr_pool[7]);
        send_request(MODE_ADD, pick_proto(), addr_pool[7]);
        send_request(MODE_ADD, pick_proto(), addr_pool[1]);
        repeat (20)
            send_request($urandom_range(0, 2) != 0 ? MODE_CHECK : MODE_REMOVE,
                         pick_proto(), pick_addr());
        send_request(MODE_CLEAR, pick_proto(), pick_addr());
        drain();

        // Random configuration with a second long stall.
        write_reg(CFG_TCP_ALLOWED, 1'($urandom_range(0, 1)));
        write_reg(CFG_ICMP_ALLOWED, 1'($urandom_range(0, 1)));
        write_reg(CFG_UDP_ALLOWED, 1'($urandom_range(0, 1)));
        long_hold_req = 1'b1;
        send_random_mix(60);
        drain();

        repeat (TABLE_DEPTH + 10) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/pif_pkg.sv
sv/pif_cell.sv
sv/protocol_and_source_ip_packet_filter.sv
sv/pif_checker.sv
tb/tb.sv
